[rtl/raip_pkg.sv]
// Shared types, constants and helpers for the radix alphabet integer parser.
// No dependencies; imported by raip_alphabet, the top level and the testbench.
package raip_pkg;

   localparam int RADIX_W          = 5;
   localparam int CFG_W            = 64;
   localparam int CSR_ADDR_W       = 5;
   localparam int ALPHABET_SYMBOLS = 16;
   localparam int SYM_INDEX_W      = 4;
   localparam int MAX_SYMBOLS_DEF  = 16;
   localparam int VALUE_WIDTH_DEF  = 32;

   localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
   localparam logic [CFG_W-1:0]   ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CFG_W-1:0]   ALPHA_HIGH_RESET = 64'h0000_0000_0000_3938;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      REG_RADIX_LENGTH  = 2'd0,
      REG_ALPHABET_LOW  = 2'd1,
      REG_ALPHABET_HIGH = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_SPACE = 4'b0001,
      PH_SIGN  = 4'b0010,
      PH_DIGIT = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                   hit;
      logic [SYM_INDEX_W-1:0] index;
   } digit_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {[CHAR_TAB:CHAR_CR]}) || (c == CHAR_SPACE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS);
   endfunction

endpackage

[rtl/raip_alphabet.sv]
// Alphabet checker and digit lookup for the radix alphabet integer parser.
// Depends on raip_pkg.
module raip_alphabet #(
   parameter int MAX_SYMBOLS = raip_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                         clock,
   input  logic [raip_pkg::RADIX_W-1:0] radix_length,
   input  logic [raip_pkg::CFG_W-1:0]   alphabet_low,
   input  logic [raip_pkg::CFG_W-1:0]   alphabet_high,
   input  logic [7:0]                   character,
   output logic                         alphabet_valid,
   output raip_pkg::digit_type          digit
);
   import raip_pkg::*;

   logic [2*CFG_W-1:0] word;
   logic [7:0]         sym [MAX_SYMBOLS];
   logic               used [MAX_SYMBOLS];
   logic               valid_in;
   logic               valid_ff;

   assign word = {alphabet_high, alphabet_low};

   always_comb begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         sym[i]  = word[8*i +: 8];
         used[i] = (RADIX_W'(i) < radix_length);
      end
   end

   // Check length, forbidden symbols and duplicates among the used symbols
   always_comb begin
      valid_in = (radix_length >= RADIX_W'(2)) && (radix_length <= RADIX_W'(MAX_SYMBOLS));
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (used[i] && ((sym[i] == CHAR_NUL) || is_space(sym[i]) || is_sign(sym[i])))
            valid_in = 1'b0;
         for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
            if (used[j] && (sym[i] == sym[j]))
               valid_in = 1'b0;
         end
      end
   end

   // Refresh every cycle; the registers settle during reset
   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
   end

   assign alphabet_valid = valid_ff;

   // Symbols are distinct whenever the result is used, so OR the matches
   always_comb begin
      digit = '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (used[i] && (sym[i] == character)) begin
            digit.hit   = 1'b1;
            digit.index = digit.index | SYM_INDEX_W'(i);
         end
      end
   end

endmodule

[rtl/radix_alphabet_integer_parser_unit.sv]
// Top level of the radix alphabet integer parser: stream ports, register file
// and parse datapath. Depends on raip_pkg and raip_alphabet.
//
// Parses one signed integer per string from a stream of characters, one
// character per transaction. A transaction with req_tuser set restarts the
// parse: leading whitespace is skipped, a run of '+' and '-' folds into a
// sign, then digits from the configured alphabet accumulate as
// value * radix + index, wrapping at VALUE_WIDTH bits. The first character
// that is not a digit (the terminating zero byte at the latest) produces one
// response transaction; later characters are dropped until the next restart.
// If the alphabet fails its check (length outside 2..MAX_SYMBOLS, a zero
// byte, whitespace, a sign or a duplicate) the first active character gives
// value 0 with the valid flag clear. One character is taken every cycle while
// the receiver keeps up. A character is held in the input register, and its
// response is loaded from there into the result register, from which the
// receiver takes it; these two register stages lie between a character and
// its response. Write the registers only while no string is being parsed.
module radix_alphabet_integer_parser_unit #(
   parameter int MAX_SYMBOLS = raip_pkg::MAX_SYMBOLS_DEF,
   parameter int VALUE_WIDTH = raip_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] character
   input  logic [0:0]                      req_tuser,   // [0] first
   // Result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((VALUE_WIDTH+7)/8)*8-1:0] rsp_tdata,  // [VALUE_WIDTH-1:0] value
   output logic [0:0]                      rsp_tuser,   // [0] alphabet_valid
   // Register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [raip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [raip_pkg::CFG_W-1:0]      csr_pwdata,
   output logic [raip_pkg::CFG_W-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import raip_pkg::*;

   localparam int RSP_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   // Registers
   logic [RADIX_W-1:0] radix_ff;
   logic [CFG_W-1:0]   alpha_low_ff;
   logic [CFG_W-1:0]   alpha_high_ff;
   reg_index_type      reg_index;
   logic               csr_write;

   // Input register
   logic               in_valid_ff;
   logic [7:0]         char_ff;
   logic               first_ff;

   // Parse state
   phase_type               phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;

   // Result register
   logic                    out_valid_ff;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic                    flag_ff, flag_in;
   logic                    result;

   logic                    fire;
   logic                    alphabet_valid;
   digit_type               digit;

   phase_type               ph;
   logic                    neg;
   logic [VALUE_WIDTH-1:0]  acc;
   logic [VALUE_WIDTH-1:0]  product;

   // ---------------------------------------------------------------------
   // Register port: a write lands on the access cycle; pready stays high
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         alpha_low_ff  <= ALPHA_LOW_RESET;
         alpha_high_ff <= ALPHA_HIGH_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_RADIX_LENGTH:  radix_ff      <= csr_pwdata[RADIX_W-1:0];
            REG_ALPHABET_LOW:  alpha_low_ff  <= csr_pwdata;
            REG_ALPHABET_HIGH: alpha_high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_RADIX_LENGTH:  csr_prdata = {{(CFG_W-RADIX_W){1'b0}}, radix_ff};
         REG_ALPHABET_LOW:  csr_prdata = alpha_low_ff;
         REG_ALPHABET_HIGH: csr_prdata = alpha_high_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Alphabet check and digit lookup
   // ---------------------------------------------------------------------
   raip_alphabet #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_alphabet (
      .clock          (clock),
      .radix_length   (radix_ff),
      .alphabet_low   (alpha_low_ff),
      .alphabet_high  (alpha_high_ff),
      .character      (char_ff),
      .alphabet_valid (alphabet_valid),
      .digit          (digit)
   );

   // ---------------------------------------------------------------------
   // Handshake: the held character advances whenever the result register
   // is free or being emptied, so a new transaction can enter every cycle
   // while the receiver keeps up
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         char_ff  <= req_tdata;
         first_ff <= req_tuser[0];
      end
   end

   // ---------------------------------------------------------------------
   // Parse step for the held character
   // ---------------------------------------------------------------------
   assign ph      = first_ff ? PH_SPACE : phase_ff;
   assign neg     = first_ff ? 1'b0 : neg_ff;
   assign acc     = first_ff ? '0 : acc_ff;
   assign product = acc * {{(VALUE_WIDTH-RADIX_W){1'b0}}, radix_ff};

   always_comb begin
      phase_in = ph;
      neg_in   = neg;
      acc_in   = acc;
      result   = 1'b0;
      value_in = '0;
      flag_in  = 1'b0;
      if (ph != PH_DONE) begin
         if (!alphabet_valid) begin
            // Bad alphabet: report zero and stop
            phase_in = PH_DONE;
            result   = 1'b1;
         end else if ((ph == PH_SPACE) && is_space(char_ff)) begin
            // Skip leading whitespace
            phase_in = PH_SPACE;
         end else if (((ph == PH_SPACE) || (ph == PH_SIGN)) && is_sign(char_ff)) begin
            phase_in = PH_SIGN;
            neg_in   = neg ^ (char_ff == CHAR_MINUS);
         end else if (digit.hit) begin
            phase_in = PH_DIGIT;
            acc_in   = product + {{(VALUE_WIDTH-SYM_INDEX_W){1'b0}}, digit.index};
         end else begin
            // First non-digit ends the parse
            phase_in = PH_DONE;
            result   = 1'b1;
            value_in = neg ? (~acc + 1'b1) : acc;
            flag_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: hold until taken
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= result;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result) begin
         value_ff <= value_in;
         flag_ff  <= flag_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(value_ff);
   assign rsp_tuser  = flag_ff;

endmodule

[rtl/raip_checker.sv]
// Port-level checks for the radix alphabet integer parser, bound to the top
// level. Depends on radix_alphabet_integer_parser_unit.
module raip_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((VALUE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic [0:0]                       rsp_tuser,
   input logic                             csr_pready
);

   // A stalled response transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // A failed alphabet always reports zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0))
      else $error("non-zero value with invalid alphabet");

   // No response appears without an earlier character taken on the input port
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without a matching input transaction");

   // Reset empties the result register and leaves pready high
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && csr_pready)
      else $error("response pending after reset");

endmodule

bind radix_alphabet_integer_parser_unit raip_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_raip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for radix_alphabet_integer_parser_unit: directed and random text
// streams under a range of digit alphabets. Depends on raip_pkg and the RTL of the block.
module tb;
   import raip_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;     // drain time after the last result
   localparam int LONG_HOLD     = 300;   // receiver hold-off that backs the block up
   localparam int TEXT_TARGET   = 1800;  // characters to offer to the block
   localparam int QUIET_FROM    = 1500;  // past this, neither side idles

   // Ways of spoiling an otherwise good alphabet
   typedef enum int {FLAW_NONE, FLAW_NUL, FLAW_BLANK, FLAW_SIGN, FLAW_TWIN} alphabet_flaw_t;

   typedef struct packed {
      logic [31:0] value;
      logic        valid;
   } parse_result_t;

   typedef struct packed {
      logic        first;
      logic [7:0]  ch;
      logic        fixed;   // expected result typed in below
      logic [31:0] value;
      logic        valid;
   } text_row_t;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [7:0] character
   logic [0:0]  req_tuser   = 1'b0;   // [0] first
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] value
   logic [0:0]  rsp_tuser;            // [0] alphabet_valid
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [CFG_W-1:0]      csr_pwdata = '0;
   logic [CFG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   // Shadow of the parser: registers and parse state
   logic [4:0]  cfg_radix      = RADIX_RESET;
   logic [63:0] cfg_alpha_low  = ALPHA_LOW_RESET;
   logic [63:0] cfg_alpha_high = ALPHA_HIGH_RESET;
   phase_type   text_phase     = PH_DONE;
   logic        text_negative  = 1'b0;
   logic [31:0] text_total     = 32'd0;

   parse_result_t pending_results[$];
   logic [7:0]    digit_set [16];
   int            digit_count   = 10;
   int            items_taken   = 0;
   int            failures      = 0;
   int            cycle_count   = 0;
   bit            quiet         = 1'b0;
   bit            long_hold_due = 1'b0;

   // Opening stimulus under the reset alphabet "0123456789"
   text_row_t opening_rows [24] = '{
      '{1'b0, "5",        1'b0, 32'd0,          1'b0},  // finished after reset: dropped
      '{1'b1, CHAR_SPACE, 1'b0, 32'd0,          1'b0},
      '{1'b0, CHAR_TAB,   1'b0, 32'd0,          1'b0},
      '{1'b0, CHAR_CR,    1'b0, 32'd0,          1'b0},
      '{1'b0, CHAR_MINUS, 1'b0, 32'd0,          1'b0},
      '{1'b0, CHAR_PLUS,  1'b0, 32'd0,          1'b0},
      '{1'b0, "2",        1'b0, 32'd0,          1'b0},
      '{1'b0, "1",        1'b0, 32'd0,          1'b0},
      '{1'b0, "4",        1'b0, 32'd0,          1'b0},
      '{1'b0, "7",        1'b0, 32'd0,          1'b0},
      '{1'b0, "4",        1'b0, 32'd0,          1'b0},
      '{1'b0, "8",        1'b0, 32'd0,          1'b0},
      '{1'b0, "3",        1'b0, 32'd0,          1'b0},
      '{1'b0, "6",        1'b0, 32'd0,          1'b0},
      '{1'b0, "4",        1'b0, 32'd0,          1'b0},
      '{1'b0, "8",        1'b0, 32'd0,          1'b0},
      '{1'b0, CHAR_NUL,   1'b1, 32'h8000_0000,  1'b1},  // most negative value
      '{1'b0, "7",        1'b0, 32'd0,          1'b0},  // trailing text: dropped
      '{1'b1, 8'hFF,      1'b1, 32'd0,          1'b1},  // no digits at all
      '{1'b1, "1",        1'b0, 32'd0,          1'b0},
      '{1'b1, "3",        1'b0, 32'd0,          1'b0},  // restart in mid-number
      '{1'b0, CHAR_MINUS, 1'b1, 32'd3,          1'b1},  // sign after digits ends it
      '{1'b1, 8'h0A,      1'b0, 32'd0,          1'b0},
      '{1'b0, CHAR_NUL,   1'b1, 32'd0,          1'b1}   // whitespace only
   };

   radix_alphabet_integer_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic blank_char(input logic [7:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

   function automatic logic [7:0] symbol_of(input int i);
      return (i < 8) ? cfg_alpha_low[i*8 +: 8] : cfg_alpha_high[(i-8)*8 +: 8];
   endfunction

   // An alphabet is usable when it holds 2..16 distinct symbols, none of them
   // the zero byte, whitespace or a sign
   function automatic logic alphabet_usable();
      logic [7:0] s;
      if (cfg_radix < 2 || cfg_radix > MAX_SYMBOLS_DEF)
         return 1'b0;
      for (int i = 0; i < cfg_radix; i++) begin
         s = symbol_of(i);
         if (s == CHAR_NUL || blank_char(s) || s == CHAR_PLUS || s == CHAR_MINUS)
            return 1'b0;
         for (int j = i + 1; j < cfg_radix; j++)
            if (symbol_of(j) == s)
               return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic int digit_index(input logic [7:0] c);
      int n;
      n = (cfg_radix > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(cfg_radix);
      for (int i = 0; i < n; i++)
         if (symbol_of(i) == c)
            return i;
      return -1;
   endfunction

   // Advance the shadow parse by one character; returns 1 when a result is due
   function automatic bit parse_character(input logic first, input logic [7:0] ch,
                                          output parse_result_t outcome);
      int idx;
      outcome = '0;
      if (first) begin
         text_phase    = PH_SPACE;
         text_negative = 1'b0;
         text_total    = 32'd0;
      end
      if (text_phase == PH_DONE)
         return 1'b0;
      if (!alphabet_usable()) begin
         text_phase = PH_DONE;
         return 1'b1;
      end
      if (text_phase == PH_SPACE) begin
         if (blank_char(ch))
            return 1'b0;
         text_phase = PH_SIGN;
      end
      if (text_phase == PH_SIGN) begin
         if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
            if (ch == CHAR_MINUS)
               text_negative = ~text_negative;
            return 1'b0;
         end
         text_phase = PH_DIGIT;
      end
      idx = digit_index(ch);
      if (idx >= 0) begin
         text_total = text_total * 32'(cfg_radix) + 32'(idx);
         return 1'b0;
      end
      text_phase    = PH_DONE;
      outcome.value = text_negative ? -text_total : text_total;
      outcome.valid = 1'b1;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Offer one character, now and then after a random gap, and predict on acceptance
   task automatic send_char(input logic first, input logic [7:0] ch, input logic fixed,
                            input parse_result_t typed);
      parse_result_t outcome;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_taken++;
      if (parse_character(first, ch, outcome))
         pending_results.push_back(fixed ? typed : outcome);
   endtask

   // Hold the sender until every result is in and the pipeline has emptied
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(8 * int'(idx));
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_RADIX_LENGTH:  cfg_radix      = data[4:0];
         REG_ALPHABET_LOW:  cfg_alpha_low  = data;
         REG_ALPHABET_HIGH: cfg_alpha_high = data;
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Draw sixteen distinct legal symbols, spoil the used part as asked and load them
   task automatic program_alphabet(input logic [4:0] radix, input alphabet_flaw_t flaw);
      bit          taken [256];
      logic [7:0]  c;
      logic [63:0] low_word, high_word;
      int          n, i, j;
      foreach (taken[k]) taken[k] = 1'b0;
      for (i = 0; i < 16; i++) begin
         do c = 8'($urandom);
         while (c == CHAR_NUL || blank_char(c) || c == CHAR_PLUS || c == CHAR_MINUS || taken[c]);
         taken[c]     = 1'b1;
         digit_set[i] = c;
      end
      n = (radix > 16) ? 16 : int'(radix);
      digit_count = n;
      if (n >= 2) begin
         i = $urandom_range(0, n - 1);
         case (flaw)
            FLAW_NUL:   digit_set[i] = CHAR_NUL;
            FLAW_BLANK: digit_set[i] = ($urandom_range(0, 5) == 5) ? CHAR_SPACE
                                       : CHAR_TAB + 8'($urandom_range(0, 4));
            FLAW_SIGN:  digit_set[i] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
            FLAW_TWIN: begin
               i = $urandom_range(0, n - 2);
               j = $urandom_range(i + 1, n - 1);
               digit_set[j] = digit_set[i];
            end
            default: ;
         endcase
      end
      for (i = 0; i < 8; i++) begin
         low_word[i*8 +: 8]  = digit_set[i];
         high_word[i*8 +: 8] = digit_set[i+8];
      end
      // Junk above the radix field must be dropped by the register
      write_register(REG_RADIX_LENGTH, {32'($urandom), 27'($urandom), radix});
      write_register(REG_ALPHABET_LOW, low_word);
      write_register(REG_ALPHABET_HIGH, high_word);
   endtask

   // One well-formed string with random content, or now and then a burst of noise
   task automatic send_text();
      logic [7:0] text [$];
      int         n;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) send_char($urandom_range(0, 3) == 0, 8'($urandom), 1'b0, '0);
         return;
      end
      n = ($urandom_range(0, 4) > 2) ? $urandom_range(1, 3) : 0;
      repeat (n) text.push_back(($urandom_range(0, 5) == 5) ? CHAR_SPACE
                                : CHAR_TAB + 8'($urandom_range(0, 4)));
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) text.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
      // Mostly short numbers; some long enough to wrap
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
      if (digit_count > 0)
         repeat (n) text.push_back(digit_set[$urandom_range(0, digit_count - 1)]);
      text.push_back(($urandom_range(0, 3) != 0) ? CHAR_NUL : 8'($urandom));
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
      foreach (text[k]) send_char(k == 0, text[k], 1'b0, '0);
   endtask

   // Load an alphabet, run text through it, close the last string and let it drain
   task automatic run_alphabet(input logic [4:0] radix, input alphabet_flaw_t flaw,
                               input bit hold_receiver);
      int budget;
      budget = (flaw == FLAW_NONE && radix >= 2 && radix <= 16) ? 150 : 40;
      program_alphabet(radix, flaw);
      if (hold_receiver)
         long_hold_due = 1'b1;
      while (budget > 0) begin
         send_text();
         budget -= 8;
      end
      send_char(1'b1, CHAR_NUL, 1'b0, '0);
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off on request, none at the end
   // ------------------------------------------------------------------
   initial begin
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: compare each response with the oldest expectation
   // ------------------------------------------------------------------
   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10)
         $display("%0t: %s", $time, what);
   endfunction

   always @(posedge clock) begin
      parse_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result: value %0d valid %0b",
                                   $signed(rsp_tdata), rsp_tuser[0]));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value || rsp_tuser[0] !== want.valid)
               note_failure($sformatf("expected value %0d valid %0b, got value %0d valid %0b",
                                      $signed(want.value), want.valid,
                                      $signed(rsp_tdata), rsp_tuser[0]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      alphabet_flaw_t flaw;
      logic [4:0]     radix;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed text under the reset alphabet
      foreach (opening_rows[i])
         send_char(opening_rows[i].first, opening_rows[i].ch, opening_rows[i].fixed,
                   {opening_rows[i].value, opening_rows[i].valid});
      wait_idle();

      // Extremes of the radix and each way an alphabet can be spoilt; the first base-16
      // run also backs the block up behind a long receiver hold-off
      run_alphabet(5'd2,  FLAW_NONE,  1'b0);
      run_alphabet(5'd16, FLAW_NONE,  1'b1);
      run_alphabet(5'd0,  FLAW_NONE,  1'b0);
      run_alphabet(5'd1,  FLAW_NONE,  1'b0);
      run_alphabet(5'd17, FLAW_NONE,  1'b0);
      run_alphabet(5'd31, FLAW_NONE,  1'b0);
      run_alphabet(5'd10, FLAW_NUL,   1'b0);
      run_alphabet(5'd5,  FLAW_BLANK, 1'b0);
      run_alphabet(5'd7,  FLAW_SIGN,  1'b0);
      run_alphabet(5'd12, FLAW_TWIN,  1'b0);
      run_alphabet(5'd16, FLAW_TWIN,  1'b0);

      // Random alphabets until enough text has been sent
      while (items_taken < TEXT_TARGET) begin
         if (items_taken >= QUIET_FROM)
            quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            radix = 5'($urandom_range(0, 31));
            flaw  = FLAW_NONE;
         end else begin
            radix = 5'($urandom_range(2, 16));
            flaw  = ($urandom_range(0, 4) == 0) ? alphabet_flaw_t'($urandom_range(1, 4))
                                                 : FLAW_NONE;
         end
         run_alphabet(radix, flaw, 1'b0);
      end

      // Anything still pending counts against the run
      wait_idle();
      repeat (20) @(posedge clock);
      failures += pending_results.size();
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
rtl/raip_pkg.sv
rtl/raip_alphabet.sv
rtl/radix_alphabet_integer_parser_unit.sv
rtl/raip_checker.sv
tb/tb.sv
